/* design/bse_pkg.sv */
// Shared types, opcodes and widths for the bitmap set engine.
// No dependencies; the engine top, scan unit and checker refer to this package by scoped names.
package bse_pkg;

    localparam int SET_BITS_DEF  = 256;
    localparam int WORD_BITS_DEF = 32;

    localparam int OPCODE_W = 5;
    localparam int ELEM_W   = 8;
    localparam int WIDX_W   = 3;
    localparam int WVAL_W   = 32;
    localparam int VALUE_W  = 9;
    localparam int MAXE_W   = 8;

    localparam logic [MAXE_W-1:0] MAXE_RESET = 8'd255;

    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_INCLUDE    = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_EXCLUDE    = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_SINGLE     = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_COMPLEMENT = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_TEST       = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_MIN        = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_MAX        = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_EXTRACT    = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_COUNT      = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_EMPTY      = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_UNION      = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_DIFF       = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_INTERSECT  = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_SYMDIFF    = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_ASSIGN     = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_SUBSET     = 5'd16;
    localparam logic [OPCODE_W-1:0] OP_EQUAL      = 5'd17;
    localparam logic [OPCODE_W-1:0] OP_READ       = 5'd18;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [ELEM_W-1:0]   el;
        logic [WIDX_W-1:0]   wi;
        logic [WVAL_W-1:0]   wv;
        logic                err;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic step;
        logic trim;
    } t_scan_ctl;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [WVAL_W-1:0]  word_out;
        logic               flag;
        logic               error;
    } t_res;

endpackage

/* design/bitmap_set_engine.sv */
// Each item passes the whole set, NWORDS words (8 by default), through the scan unit: the set rotates
// one stored word per cycle, except that the last word waits while the previous result is stalled;
// the result register loads on the last word and the next beat can be taken in that same cycle.
// A max_element write sets a pending flag that starts a trim pass over all NWORDS words once idle;
// o_ready stays low from the write to the end of the pass.
// Synchronous active-low reset: set empty, max_element 255, no result pending.
// Top level; depends on bse_pkg, bse_word_ring and bse_scan_unit.
module bitmap_set_engine #(
    parameter int SET_BITS  = bse_pkg::SET_BITS_DEF,
    parameter int WORD_BITS = bse_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bse_pkg::MAXE_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bse_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [bse_pkg::ELEM_W-1:0]    i_element,
    input  logic [bse_pkg::WIDX_W-1:0]    i_word_index,
    input  logic [bse_pkg::WVAL_W-1:0]    i_word_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bse_pkg::VALUE_W-1:0]   o_value,
    output logic [bse_pkg::WVAL_W-1:0]    o_word_out,
    output logic                          o_flag,
    output logic                          o_error
);

    localparam int NWORDS    = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int POS_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IDX_W_RAW = $clog2(NWORDS * WORD_BITS + 1);
    localparam int IDX_W     = (IDX_W_RAW > 9) ? IDX_W_RAW : 9;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                        r_state;
    logic [POS_W-1:0]            r_pos;
    logic                        r_trim;
    logic                        r_trim_pend;
    logic [bse_pkg::MAXE_W-1:0]  r_max_element;
    logic                        r_out_valid;
    bse_pkg::t_cmd               r_cmd;
    bse_pkg::t_res               r_res;

    logic [IDX_W-1:0]            w_max_eff;
    logic                        w_last;
    logic                        w_step;
    logic                        w_accept;
    logic                        w_done;
    logic                        w_elem_op;
    logic                        w_word_op;
    bse_pkg::t_cmd               w_in_cmd;
    bse_pkg::t_scan_ctl          w_ctl;
    bse_pkg::t_res               w_scan_res;
    logic [WORD_BITS-1:0]        w_head;
    logic [WORD_BITS-1:0]        w_new;

    assign w_max_eff = (IDX_W'(r_max_element) > IDX_W'(SET_BITS - 1)) ?
                       IDX_W'(SET_BITS - 1) : IDX_W'(r_max_element);
    assign w_last    = r_pos == POS_W'(NWORDS - 1);
    assign w_step    = (r_state == ST_RUN) &&
                       !(w_last && !r_trim && r_out_valid && !i_ready);
    assign w_done    = w_step && w_last && !r_trim;
    assign o_ready   = !i_cfg_we && !r_trim_pend && ((r_state == ST_IDLE) || w_done);
    assign w_accept  = i_valid && o_ready;

    assign w_elem_op = (i_opcode == bse_pkg::OP_INCLUDE) || (i_opcode == bse_pkg::OP_EXCLUDE) ||
                       (i_opcode == bse_pkg::OP_SINGLE)  || (i_opcode == bse_pkg::OP_TEST);
    assign w_word_op = (i_opcode >= bse_pkg::OP_UNION) && (i_opcode <= bse_pkg::OP_READ);

    always_comb begin
        w_in_cmd.op  = i_opcode;
        w_in_cmd.el  = i_element;
        w_in_cmd.wi  = i_word_index;
        w_in_cmd.wv  = i_word_value;
        w_in_cmd.err = (w_elem_op && (IDX_W'(i_element) > w_max_eff)) ||
                       (w_word_op && (32'(i_word_index) >= 32'(NWORDS)));
    end

    assign w_ctl.first = r_pos == '0;
    assign w_ctl.step  = w_step;
    assign w_ctl.trim  = r_trim;

    bse_word_ring #(
        .WORD_BITS (WORD_BITS),
        .NWORDS    (NWORDS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_step),
        .i_word  (w_new),
        .o_head  (w_head)
    );

    bse_scan_unit #(
        .WORD_BITS (WORD_BITS),
        .NWORDS    (NWORDS),
        .IDX_W     (IDX_W),
        .POS_W     (POS_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_cmd     (r_cmd),
        .i_pos     (r_pos),
        .i_max_eff (w_max_eff),
        .i_head    (w_head),
        .o_new     (w_new),
        .o_res     (w_scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_trim        <= 1'b0;
            r_trim_pend   <= 1'b0;
            r_max_element <= bse_pkg::MAXE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= ST_RUN;
                r_pos   <= '0;
                r_trim  <= 1'b0;
            end else if (r_state == ST_IDLE && r_trim_pend && !i_cfg_we) begin
                r_state     <= ST_RUN;
                r_pos       <= '0;
                r_trim      <= 1'b1;
                r_trim_pend <= 1'b0;
            end else if (w_step) begin
                if (w_last) begin
                    r_state <= ST_IDLE;
                    r_pos   <= '0;
                    r_trim  <= 1'b0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_cfg_we) begin
                r_max_element <= i_cfg_data;
                r_trim_pend   <= 1'b1;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_in_cmd;
        end
        if (w_done) begin
            r_res <= w_scan_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_res.value;
    assign o_word_out = r_res.word_out;
    assign o_flag     = r_res.flag;
    assign o_error    = r_res.error;

endmodule

/* design/bse_word_ring.sv */
// Rotating word ring that holds the set; one word leaves the head and one enters the tail per step.
// Depends on nothing beyond its parameters.
module bse_word_ring #(
    parameter int WORD_BITS = 32,
    parameter int NWORDS    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [WORD_BITS-1:0] i_word,
    output logic [WORD_BITS-1:0] o_head
);

    logic [WORD_BITS-1:0] r_ring [NWORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NWORDS; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_shift) begin
            for (int i = 0; i < NWORDS - 1; i++) begin
                r_ring[i] <= r_ring[i + 1];
            end
            r_ring[NWORDS-1] <= i_word;
        end
    end

    assign o_head = r_ring[0];

endmodule

/* design/bse_scan_unit.sv */
// Per-word operation unit and result accumulators (min, max, count, flag, word).
// Depends on bse_pkg for opcodes, command and result types.
module bse_scan_unit #(
    parameter int WORD_BITS = 32,
    parameter int NWORDS    = 8,
    parameter int IDX_W     = 9,
    parameter int POS_W     = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bse_pkg::t_scan_ctl   i_ctl,
    input  bse_pkg::t_cmd        i_cmd,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [IDX_W-1:0]     i_max_eff,
    input  logic [WORD_BITS-1:0] i_head,
    output logic [WORD_BITS-1:0] o_new,
    output bse_pkg::t_res        o_res
);

    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int PC_W  = $clog2(WORD_BITS + 1);
    localparam int CNT_W = $clog2(NWORDS * WORD_BITS + 1);
    localparam int CMP_W = (POS_W > bse_pkg::WIDX_W) ? POS_W : bse_pkg::WIDX_W;

    logic [IDX_W-1:0]     w_base;
    logic [IDX_W-1:0]     w_el;
    logic                 w_el_hit;
    logic                 w_wi_hit;
    logic [BIT_W-1:0]     w_bit;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_oper;
    logic [WORD_BITS-1:0] w_v;
    logic [WORD_BITS-1:0] w_s;
    logic [WORD_BITS-1:0] w_s_m;
    logic [BIT_W-1:0]     w_lo;
    logic [BIT_W-1:0]     w_hi;
    logic [PC_W-1:0]      w_pc;
    logic                 w_nz;

    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_val,   n_val;
    logic [CNT_W-1:0]     r_cnt,   n_cnt;
    logic                 r_flag,  n_flag;
    logic [WORD_BITS-1:0] r_word,  n_word;

    assign w_base   = IDX_W'(i_pos) * IDX_W'(WORD_BITS);
    assign w_el     = IDX_W'(i_cmd.el);
    assign w_el_hit = (w_el >= w_base) && (w_el < w_base + IDX_W'(WORD_BITS));
    assign w_bit    = BIT_W'(w_el - w_base);
    assign w_wi_hit = CMP_W'(i_cmd.wi) == CMP_W'(i_pos);
    assign w_oper   = WORD_BITS'(i_cmd.wv);
    assign w_v      = w_oper & w_mask;
    assign w_nz     = |i_head;
    assign w_s_m    = w_s & w_mask;

    always_comb begin
        w_mask = '0;
        w_lo   = '0;
        w_hi   = '0;
        w_pc   = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            w_mask[b] = (w_base + IDX_W'(b)) <= i_max_eff;
            w_pc      = w_pc + PC_W'(i_head[b]);
            if (i_head[b]) begin
                w_hi = BIT_W'(b);
            end
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (i_head[b]) begin
                w_lo = BIT_W'(b);
            end
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            bse_pkg::OP_UNION:     w_s = i_head | w_v;
            bse_pkg::OP_DIFF:      w_s = i_head & ~w_v;
            bse_pkg::OP_INTERSECT: w_s = i_head & w_v;
            bse_pkg::OP_SYMDIFF:   w_s = i_head ^ w_v;
            bse_pkg::OP_ASSIGN:    w_s = w_v;
            default:               w_s = i_head;
        endcase
    end

    always_comb begin
        o_new = i_head;
        if (i_ctl.first) begin
            n_found = 1'b0;
            n_val   = '0;
            n_cnt   = '0;
            n_flag  = 1'b0;
            n_word  = '0;
        end else begin
            n_found = r_found;
            n_val   = r_val;
            n_cnt   = r_cnt;
            n_flag  = r_flag;
            n_word  = r_word;
        end
        if (i_ctl.trim) begin
            o_new = i_head & w_mask;
        end else if (!i_cmd.err) begin
            unique case (i_cmd.op)
                bse_pkg::OP_CLEAR: begin
                    o_new = '0;
                end
                bse_pkg::OP_INCLUDE: begin
                    if (w_el_hit) begin
                        o_new[w_bit] = 1'b1;
                    end
                end
                bse_pkg::OP_EXCLUDE: begin
                    if (w_el_hit) begin
                        o_new[w_bit] = 1'b0;
                    end
                end
                bse_pkg::OP_SINGLE: begin
                    o_new = '0;
                    if (w_el_hit) begin
                        o_new[w_bit] = 1'b1;
                    end
                end
                bse_pkg::OP_COMPLEMENT: begin
                    o_new = ~i_head & w_mask;
                end
                bse_pkg::OP_TEST: begin
                    if (w_el_hit) begin
                        n_flag = i_head[w_bit];
                    end
                end
                bse_pkg::OP_MIN: begin
                    if (!n_found && w_nz) begin
                        n_found = 1'b1;
                        n_val   = w_base + IDX_W'(w_lo);
                    end
                end
                bse_pkg::OP_MAX: begin
                    if (w_nz) begin
                        n_val = w_base + IDX_W'(w_hi);
                    end
                end
                bse_pkg::OP_EXTRACT: begin
                    if (!n_found && w_nz) begin
                        n_found = 1'b1;
                        n_val   = w_base + IDX_W'(w_lo);
                        o_new   = i_head & (i_head - WORD_BITS'(1));
                    end
                end
                bse_pkg::OP_COUNT: begin
                    n_cnt = n_cnt + CNT_W'(w_pc);
                end
                bse_pkg::OP_EMPTY: begin
                    n_flag = (i_ctl.first ? 1'b1 : r_flag) & ~w_nz;
                end
                bse_pkg::OP_UNION, bse_pkg::OP_DIFF, bse_pkg::OP_INTERSECT,
                bse_pkg::OP_SYMDIFF, bse_pkg::OP_ASSIGN, bse_pkg::OP_SUBSET,
                bse_pkg::OP_EQUAL, bse_pkg::OP_READ: begin
                    if (w_wi_hit) begin
                        o_new  = w_s_m;
                        n_word = w_s_m;
                        if (i_cmd.op == bse_pkg::OP_SUBSET) begin
                            n_flag = (i_head & ~w_v) == '0;
                        end
                        if (i_cmd.op == bse_pkg::OP_EQUAL) begin
                            n_flag = i_head == w_v;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_val   <= '0;
            r_cnt   <= '0;
            r_flag  <= 1'b0;
            r_word  <= '0;
        end else if (i_ctl.step) begin
            r_found <= n_found;
            r_val   <= n_val;
            r_cnt   <= n_cnt;
            r_flag  <= n_flag;
            r_word  <= n_word;
        end
    end

    always_comb begin
        if (i_cmd.op == bse_pkg::OP_COUNT) begin
            o_res.value = bse_pkg::VALUE_W'(n_cnt);
        end else begin
            o_res.value = bse_pkg::VALUE_W'(n_val);
        end
        o_res.word_out = bse_pkg::WVAL_W'(n_word);
        o_res.flag     = n_flag;
        o_res.error    = i_cmd.err;
    end

endmodule

/* design/bse_checker.sv */
// Port-level checker for bitmap_set_engine and the bind that attaches it.
// Depends on bse_pkg for port widths.
module bse_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [bse_pkg::VALUE_W-1:0]   o_value,
    input logic [bse_pkg::WVAL_W-1:0]    o_word_out,
    input logic                          o_flag,
    input logic                          o_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_word_out) &&
                                $stable(o_flag) && $stable(o_error))
        else $error("result beat changed while stalled");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_value == '0 && o_word_out == '0 && !o_flag)
        else $error("rejected item carries a nonzero answer");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_value <= 9'd256)
        else $error("value beyond cardinality bound");

    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("input taken before trim after config write");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (.*);
